// ===== src/pap_pkg.sv =====
`timescale 1ns / 1ps
package pap_pkg;

   localparam int NumArt = 5;
   localparam int PosW = 13;
   localparam int DurW = 7;
   localparam int SpeedW = 13;
   localparam int QuoW = 19;

   localparam logic [PosW-1:0] PosNeutral = 13'd2048;
   localparam logic [8:0] StrengthOne = 9'd256;
   localparam logic [QuoW-1:0] SpeedMin = 19'd256;
   localparam logic [QuoW-1:0] SpeedMax = 19'd5120;

   localparam logic [1:0] RegBlendEnable = 2'd0;
   localparam logic [1:0] RegBlendStrength = 2'd1;
   localparam logic [1:0] RegStartTime = 2'd2;

   typedef struct packed {
      logic [DurW-1:0] dur;
      logic [NumArt-1:0][PosW-1:0] pos;
   } entry_type;

   // Hundredths to unsigned Q1.12, rounded half up.
   function automatic logic [PosW-1:0] hund_to_pos(input logic [6:0] h);
      logic [PosW-1:0] p;
      case (h)
         7'd10: p = 13'd410;
         7'd15: p = 13'd614;
         7'd20: p = 13'd819;
         7'd30: p = 13'd1229;
         7'd35: p = 13'd1434;
         7'd40: p = 13'd1638;
         7'd50: p = 13'd2048;
         7'd60: p = 13'd2458;
         7'd70: p = 13'd2867;
         7'd80: p = 13'd3277;
         7'd90: p = 13'd3686;
         7'd100: p = 13'd4096;
         default: p = '0;
      endcase
      return p;
   endfunction

   function automatic entry_type mk(input int h0, input int h1,
                                    input int h2, input int h3,
                                    input int h4, input int d);
      entry_type e;
      e.dur = DurW'(d);
      e.pos[0] = hund_to_pos(7'(h0));
      e.pos[1] = hund_to_pos(7'(h1));
      e.pos[2] = hund_to_pos(7'(h2));
      e.pos[3] = hund_to_pos(7'(h3));
      e.pos[4] = hund_to_pos(7'(h4));
      return e;
   endfunction

   function automatic entry_type rom_lookup(input logic [7:0] code);
      entry_type e;
      case (code)
         8'd0: e = mk(50, 50, 50, 0, 0, 50);
         " ": e = mk(50, 50, 50, 0, 0, 50);
         "_": e = mk(50, 50, 50, 0, 0, 100);
         "i": e = mk(70, 10, 30, 80, 0, 70);
         "I": e = mk(60, 20, 40, 80, 0, 65);
         "e": e = mk(70, 20, 50, 80, 0, 75);
         "E": e = mk(70, 30, 60, 80, 0, 80);
         "&": e = mk(80, 30, 80, 80, 0, 85);
         "@": e = mk(60, 50, 50, 70, 0, 60);
         "3": e = mk(60, 50, 60, 80, 0, 90);
         "V": e = mk(70, 50, 70, 80, 0, 75);
         "u": e = mk(20, 90, 30, 80, 0, 70);
         "U": e = mk(30, 80, 40, 80, 0, 65);
         "o": e = mk(40, 80, 50, 80, 0, 75);
         "O": e = mk(50, 70, 60, 80, 0, 80);
         "a": e = mk(80, 60, 90, 80, 0, 85);
         "A": e = mk(80, 80, 90, 80, 0, 90);
         "Q": e = mk(60, 90, 80, 80, 0, 85);
         "y": e = mk(30, 10, 30, 80, 0, 75);
         "Y": e = mk(40, 20, 40, 80, 0, 70);
         "2": e = mk(40, 20, 50, 80, 0, 80);
         "9": e = mk(50, 30, 60, 80, 0, 85);
         "p": e = mk(0, 50, 30, 0, 0, 60);
         "b": e = mk(0, 50, 30, 90, 0, 65);
         "t": e = mk(50, 20, 30, 0, 0, 55);
         "d": e = mk(50, 20, 30, 90, 0, 60);
         "k": e = mk(50, 80, 40, 0, 0, 65);
         "g": e = mk(50, 80, 40, 90, 0, 70);
         "?": e = mk(50, 50, 50, 0, 0, 40);
         "f": e = mk(10, 50, 40, 0, 0, 90);
         "v": e = mk(10, 50, 40, 90, 0, 85);
         "T": e = mk(40, 15, 40, 0, 0, 95);
         "D": e = mk(40, 15, 40, 90, 0, 90);
         "s": e = mk(50, 20, 40, 0, 0, 100);
         "z": e = mk(50, 20, 40, 90, 0, 95);
         "S": e = mk(40, 35, 40, 0, 0, 100);
         "Z": e = mk(40, 35, 40, 90, 0, 95);
         "C": e = mk(50, 30, 40, 0, 0, 90);
         "x": e = mk(50, 80, 50, 0, 0, 85);
         "G": e = mk(50, 80, 50, 90, 0, 80);
         "h": e = mk(70, 50, 60, 0, 0, 80);
         "m": e = mk(0, 50, 40, 90, 100, 75);
         "n": e = mk(50, 20, 40, 90, 100, 70);
         "N": e = mk(50, 80, 40, 90, 100, 75);
         "J": e = mk(50, 30, 40, 90, 100, 70);
         "l": e = mk(60, 20, 50, 90, 0, 65);
         "L": e = mk(60, 80, 50, 90, 0, 70);
         "r": e = mk(60, 35, 50, 90, 0, 70);
         "R": e = mk(60, 90, 50, 90, 0, 75);
         "4": e = mk(60, 20, 50, 90, 0, 40);
         "w": e = mk(20, 90, 40, 90, 0, 60);
         "j": e = mk(70, 10, 40, 90, 0, 55);
         "H": e = mk(30, 10, 40, 90, 0, 55);
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

// ===== src/pap_ram.sv =====
`timescale 1ns / 1ps
module pap_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 5
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/phoneme_articulator_planner.sv =====
`timescale 1ns / 1ps
// One phoneme yields five commands, one per articulator, handled in turn.
// Each articulator steps through read, calc and emit, with the bit-serial speed divider between
// calc and emit when the duration is nonzero; output stalls hold the emit state.
// Input is taken only between phonemes. Synchronous reset restores register defaults;
// stored positions read as neutral.
module phoneme_articulator_planner import pap_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] phoneme_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [12:0] target_position, [25:13] move_speed, [57:26] start_stamp_ms,
   // [65:58] echo_phoneme, [71:66] zero
   output logic [71:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] articulator
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StRead = 3'd1;
   localparam logic [2:0] StCalc = 3'd2;
   localparam logic [2:0] StDiv  = 3'd3;
   localparam logic [2:0] StEmit = 3'd4;
   localparam int AddrW = $clog2(NumArt);
   localparam logic [AddrW-1:0] LastArt = AddrW'(NumArt - 1);

   logic [2:0] state_ff, state_in;
   logic       en_ff;
   logic [8:0] strength_ff;
   logic [TIME_WIDTH-1:0] next_time_ff, next_time_in;
   logic [7:0] prev_ff;
   logic       prev_valid_ff;
   logic [NumArt-1:0] pos_valid_ff;

   logic [7:0] code_ff;
   logic       mix_ff;
   logic [8:0] s_ff;
   logic [AddrW-1:0] art_ff;
   logic [PosW-1:0]  t_ff, t_in;
   logic [QuoW-1:0]  num_ff;
   logic [7:0]       rem_ff;
   logic [4:0]       cnt_ff;

   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff;
   logic [2:0]  rsp_user_ff;
   logic        rsp_last_ff;

   entry_type cur_e, prev_e;
   logic [DurW-1:0] dur;
   logic [21:0] blend_sum;
   logic [PosW-1:0] ram_rdata, pos_old, pos_dist;
   logic [QuoW-1:0] num_in, speed;
   logic [8:0]  trial;
   logic        emit_go, req_fire;

   assign cur_e  = rom_lookup(code_ff);
   assign prev_e = rom_lookup(prev_ff);
   assign dur    = cur_e.dur;

   pap_ram #(.WIDTH(PosW), .DEPTH(NumArt)) u_pos_ram (
      .clock(clock),
      .we(state_ff == StEmit && emit_go),
      .waddr(art_ff),
      .wdata(t_ff),
      .raddr(art_ff),
      .rdata(ram_rdata)
   );

   assign req_tready = (state_ff == StIdle);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign emit_go    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      blend_sum = 22'(cur_e.pos[art_ff]) * 22'(StrengthOne - s_ff)
                + 22'(prev_e.pos[art_ff]) * 22'(s_ff) + 22'd128;
      t_in = mix_ff ? blend_sum[20:8] : cur_e.pos[art_ff];
      pos_old = pos_valid_ff[art_ff] ? ram_rdata : PosNeutral;
      pos_dist = (t_ff >= pos_old) ? t_ff - pos_old : pos_old - t_ff;
      // Speed is round(dist * 62.5 / dur), written as (125 d + dur) / (2 dur).
      num_in = QuoW'(pos_dist) * QuoW'(125) + QuoW'(dur);
      trial = {rem_ff, num_ff[QuoW-1]};
      if (dur == '0) begin
         speed = '0;
      end else if (num_ff < SpeedMin) begin
         speed = SpeedMin;
      end else if (num_ff > SpeedMax) begin
         speed = SpeedMax;
      end else begin
         speed = num_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: if (req_fire) state_in = StRead;
         StRead: state_in = StCalc;
         StCalc: state_in = (dur == '0) ? StEmit : StDiv;
         StDiv:  if (cnt_ff == 5'(QuoW - 1)) state_in = StEmit;
         StEmit: if (emit_go) state_in = (art_ff == LastArt) ? StIdle : StRead;
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      next_time_in = next_time_ff;
      if (state_ff == StEmit && emit_go && art_ff == LastArt) begin
         next_time_in = next_time_ff + TIME_WIDTH'(dur);
      end else if (csr_valid && csr_index == RegStartTime && !prev_valid_ff) begin
         next_time_in = TIME_WIDTH'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         en_ff         <= 1'b1;
         strength_ff   <= 9'd179;
         next_time_ff  <= TIME_WIDTH'(100);
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         pos_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_time_ff <= next_time_in;
         if (csr_valid) begin
            case (csr_index)
               RegBlendEnable:   en_ff <= csr_wdata[0];
               RegBlendStrength: strength_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == StEmit && emit_go) begin
            rsp_valid_ff <= 1'b1;
            pos_valid_ff[art_ff] <= 1'b1;
            if (art_ff == LastArt) begin
               prev_ff       <= code_ff;
               prev_valid_ff <= 1'b1;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         code_ff <= req_tdata;
         mix_ff  <= en_ff && prev_valid_ff;
         s_ff    <= (strength_ff > StrengthOne) ? StrengthOne : strength_ff;
         art_ff  <= '0;
      end
      if (state_ff == StRead) begin
         t_ff <= t_in;
      end
      if (state_ff == StCalc) begin
         num_ff <= num_in;
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      // Restoring division by 2 * dur, one quotient bit per cycle.
      if (state_ff == StDiv) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (trial >= {1'b0, dur, 1'b0}) begin
            rem_ff <= 8'(trial - 9'({dur, 1'b0}));
            num_ff <= {num_ff[QuoW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[7:0];
            num_ff <= {num_ff[QuoW-2:0], 1'b0};
         end
      end
      if (state_ff == StEmit && emit_go) begin
         rsp_data_ff <= {6'd0, code_ff, 32'(next_time_ff), speed[SpeedW-1:0], t_ff};
         rsp_user_ff <= 3'(art_ff);
         rsp_last_ff <= (art_ff == LastArt);
         if (art_ff != LastArt) begin
            art_ff <= art_ff + AddrW'(1);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top import pap_pkg::*; ();

   localparam logic [1:0] RegUnused = 2'd3;

   typedef struct {
      logic [2:0]  art;
      logic [12:0] target;
      logic [12:0] speed;
      logic [31:0] stamp;
      logic [7:0]  code;
      logic        last;
   } command_type;

   // Tracks the planner's state and holds the commands still owed by the block.
   class articulation_board;
      bit          enable;
      bit [8:0]    strength;
      bit [12:0]   position[NumArt];
      bit [7:0]    prev_code;
      bit          have_prev;
      bit [31:0]   clock_ms;
      command_type pending[$];
      int          errors;
      int          checked;

      function void clear();
         enable = 1'b1;
         strength = 9'd179;
         for (int k = 0; k < NumArt; k++) position[k] = 13'd2048;
         prev_code = '0;
         have_prev = 1'b0;
         clock_ms = 32'd100;
         pending.delete();
      endfunction

      function void write_reg(logic [1:0] idx, logic [8:0] val);
         if (idx == RegBlendEnable) enable = val[0];
         else if (idx == RegBlendStrength) strength = val;
         else if (idx == RegStartTime) begin
            if (!have_prev) clock_ms = 32'(val);
         end
      endfunction

      function bit [12:0] table_pos(bit [7:0] code, int k);
         entry_type e;
         e = rom_lookup(code);
         return e.pos[k];
      endfunction

      function void note_phoneme(bit [7:0] code);
         entry_type e;
         longint unsigned s, t, p, d, den, q;
         command_type c;
         e = rom_lookup(code);
         s = (strength > 256) ? 256 : strength;
         for (int k = 0; k < NumArt; k++) begin
            t = table_pos(code, k);
            if (enable && have_prev) begin
               p = table_pos(prev_code, k);
               t = (t * (256 - s) + p * s + 128) >> 8;
            end
            d = (t >= position[k]) ? t - position[k] : position[k] - t;
            if (e.dur == 0) q = 0;
            else begin
               den = longint'(e.dur) << 12;
               q = (d * 256000 + den / 2) / den;
               if (q < 256) q = 256;
               if (q > 5120) q = 5120;
            end
            c.art = 3'(k);
            c.target = 13'(t);
            c.speed = 13'(q);
            c.stamp = clock_ms;
            c.code = code;
            c.last = (k == NumArt - 1);
            pending.push_back(c);
            position[k] = 13'(t);
         end
         clock_ms = clock_ms + 32'(e.dur);
         prev_code = code;
         have_prev = 1'b1;
      endfunction

      function void check_command(command_type got);
         command_type w;
         if (pending.size() == 0) begin
            $error("unexpected command art=%0d code=%0d", got.art, got.code);
            errors++;
            return;
         end
         w = pending.pop_front();
         checked++;
         if (got.art !== w.art) begin
            $error("articulator exp %0d got %0d", w.art, got.art); errors++;
         end
         if (got.target !== w.target) begin
            $error("target_position exp %0d got %0d", w.target, got.target); errors++;
         end
         if (got.speed !== w.speed) begin
            $error("move_speed exp %0d got %0d", w.speed, got.speed); errors++;
         end
         if (got.stamp !== w.stamp) begin
            $error("start_stamp_ms exp %0d got %0d", w.stamp, got.stamp); errors++;
         end
         if (got.code !== w.code) begin
            $error("echo_phoneme exp %0d got %0d", w.code, got.code); errors++;
         end
         if (got.last !== w.last) begin
            $error("run_last exp %0d got %0d", w.last, got.last); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [8:0]  csr_wdata = 0;

   articulation_board board = new();
   bit   hold_off = 0;
   int   sent = 0;
   logic [7:0] known_codes[$];

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   phoneme_articulator_planner u_top (.*);

   // Receiver: stalls on its own pattern, plus one long hold-off on request.
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off) rsp_tready <= 0;
         else if (phase % 200 < 60) rsp_tready <= 1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      command_type c;
      if (!reset && rsp_tvalid && rsp_tready) begin
         c.target = rsp_tdata[12:0];
         c.speed = rsp_tdata[25:13];
         c.stamp = rsp_tdata[57:26];
         c.code = rsp_tdata[65:58];
         c.art = rsp_tuser;
         c.last = rsp_tlast;
         board.check_command(c);
      end
   end

   task automatic send_phoneme(input logic [7:0] code);
      req_tvalid <= 1;
      req_tdata <= code;
      do @(posedge clock); while (!req_tready);
      board.note_phoneme(code);
      sent++;
   endtask

   task automatic idle_input(input int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [8:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_code();
      if ($urandom_range(0, 9) < 8) return known_codes[$urandom_range(0, known_codes.size() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_burst(input int n);
      int left;
      left = n;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 8);
         repeat (burst) if (left > 0) begin
            send_phoneme(pick_code());
            left--;
         end
         if (left > 0 && $urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
      end
      req_tvalid <= 0;
   endtask

   initial begin
      logic [7:0] directed[$];
      board.clear();
      for (int c = 0; c < 256; c++) begin
         entry_type e;
         e = rom_lookup(8'(c));
         if (e.dur != 0) known_codes.push_back(8'(c));
      end
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Start time loads the timeline only before the first phoneme.
      write_csr(RegStartTime, 9'd511);
      write_csr(RegBlendStrength, 9'd300);
      directed = '{8'd0, 8'hFF, "a", "m", "_", 8'h80, "?", "s", 8'h7F, "i", "u", 8'h01};
      foreach (directed[i]) send_phoneme(directed[i]);
      req_tvalid <= 0;
      drain();
      write_csr(RegStartTime, 9'd0);
      write_csr(RegBlendEnable, 9'd0);
      write_csr(RegUnused, 9'h1AA);
      foreach (directed[i]) send_phoneme(directed[i]);
      req_tvalid <= 0;
      drain();

      write_csr(RegBlendEnable, 9'd1);
      write_csr(RegBlendStrength, 9'd0);
      random_burst(40);
      drain();
      write_csr(RegBlendStrength, 9'd256);
      // Long hold-off on the result side while phonemes keep coming.
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         random_burst(20);
      join
      drain();
      write_csr(RegBlendStrength, 9'($urandom_range(1, 511)));
      write_csr(RegStartTime, 9'($urandom_range(0, 511)));
      random_burst(60);
      drain();
      write_csr(RegBlendStrength, 9'd179);
      random_burst(25);
      drain();

      $display("Covered %0d phonemes and %0d commands across blend settings,",
               sent, board.checked);
      $display("unlisted codes, start time writes and a long output stall.");
      if (board.errors == 0 && board.pending.size() == 0) $display("PASS phoneme_articulator_planner");
      else $display("FAIL phoneme_articulator_planner");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL phoneme_articulator_planner");
      $finish;
   end
endmodule

// ===== files.f =====
src/pap_pkg.sv
src/pap_ram.sv
src/phoneme_articulator_planner.sv
tb/tb_top.sv
